// ===== hdl/sgr_pkg.sv =====
`default_nettype none
package sgr_pkg;

  // Field widths of the ports
  localparam int CMD_W        = 2;
  localparam int ROW_W        = 6;
  localparam int COL_W        = 6;
  localparam int GRAIN_IO_W   = 32;
  localparam int COLOUR_W     = 3;
  localparam int TOPPLE_W     = 13;
  localparam int BUDGET_W     = 32;
  localparam int SIZE_CFG_W   = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SWEEP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SWEEPS = 2'd2;

  // Reset values of the configuration registers
  localparam logic [SIZE_CFG_W-1:0] SIZE_RESET   = 7'd64;
  localparam logic [BUDGET_W-1:0]   BUDGET_RESET = '1;

  // Palette indexes by grain count
  localparam logic [COLOUR_W-1:0] PAL_EMPTY = 3'd0;
  localparam logic [COLOUR_W-1:0] PAL_ONE   = 3'd3;
  localparam logic [COLOUR_W-1:0] PAL_TWO   = 3'd1;
  localparam logic [COLOUR_W-1:0] PAL_THREE = 3'd2;
  localparam logic [COLOUR_W-1:0] PAL_MANY  = 3'd4;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_CAPTURE,
    OP_LOAD,
    OP_RD_CELL,
    OP_SW_INIT,
    OP_SW_STEP_READ,
    OP_SW_TOPPLE,
    OP_NB_RD,
    OP_NB_WR,
    OP_SW_END,
    OP_PUSH
  } dp_op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic clear_last;   // clearing pass at the last cell
    logic budget_zero;  // sweep budget used up
    logic grid_empty;   // zero rows or zero columns in use
    logic cell_ge4;     // read cell holds 4 or more grains
    logic cell_has_nb;  // current sweep cell has a neighbor inside the grid
    logic nb_more;      // more than one neighbor update still pending
    logic sweep_last;   // current sweep cell is the last one in use
    logic out_free;     // output register can take a new beat
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hdl/sgr_ctrl.sv =====
`default_nettype none
module sgr_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [sgr_pkg::CMD_W-1:0]  in_cmd,
  output logic                       in_stall,
  input  sgr_pkg::dp_status_t        status,
  output sgr_pkg::dp_op_t            op
);
  import sgr_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_READ,
    S_SW_START,
    S_SW_EVAL,
    S_ADV,
    S_NB_RD,
    S_NB_WR,
    S_SW_END,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Input side is open only between items
  assign in_stall = (state_r != S_IDLE);

  // Next state and datapath operation
  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    case (state_r)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (status.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op = OP_CAPTURE;
          case (in_cmd)
            CMD_LOAD:  state_nxt = S_LOAD;
            CMD_SWEEP: state_nxt = S_SW_START;
            CMD_READ:  state_nxt = S_READ;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_LOAD: begin
        op        = OP_LOAD;
        state_nxt = S_DONE;
      end
      S_READ: begin
        op        = OP_RD_CELL;
        state_nxt = S_DONE;
      end
      S_SW_START: begin
        op = OP_SW_INIT;
        if (status.budget_zero || status.grid_empty) state_nxt = S_SW_END;
        else                                          state_nxt = S_SW_EVAL;
      end
      S_SW_EVAL: begin
        if (status.cell_ge4) begin
          op        = OP_SW_TOPPLE;
          state_nxt = status.cell_has_nb ? S_NB_RD : S_ADV;
        end else if (status.sweep_last) begin
          state_nxt = S_SW_END;
        end else begin
          op = OP_SW_STEP_READ;
        end
      end
      S_NB_RD: begin
        op        = OP_NB_RD;
        state_nxt = S_NB_WR;
      end
      S_NB_WR: begin
        op        = OP_NB_WR;
        state_nxt = status.nb_more ? S_NB_RD : S_ADV;
      end
      S_ADV: begin
        // last neighbor write is done, so the next cell reads fresh data
        if (status.sweep_last) begin
          state_nxt = S_SW_END;
        end else begin
          op        = OP_SW_STEP_READ;
          state_nxt = S_SW_EVAL;
        end
      end
      S_SW_END: begin
        op        = OP_SW_END;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          op        = OP_PUSH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sgr_datapath.sv =====
`default_nettype none
module sgr_datapath #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int GRAIN_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sgr_pkg::dp_op_t                  op,
  output sgr_pkg::dp_status_t              status,
  input  logic                             cfg_we,
  input  logic [sgr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sgr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [sgr_pkg::CMD_W-1:0]        in_cmd,
  input  logic [sgr_pkg::ROW_W-1:0]        in_row,
  input  logic [sgr_pkg::COL_W-1:0]        in_col,
  input  logic [sgr_pkg::GRAIN_IO_W-1:0]   in_grains_in,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [sgr_pkg::GRAIN_IO_W-1:0]   out_grains_out,
  output logic [sgr_pkg::COLOUR_W-1:0]     out_colour,
  output logic [sgr_pkg::TOPPLE_W-1:0]     out_topple_count,
  output logic                             out_stable,
  output logic [sgr_pkg::BUDGET_W-1:0]     out_sweeps_remaining
);
  import sgr_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RLW   = $clog2(MAX_ROWS + 1);
  localparam int CLW   = $clog2(MAX_COLS + 1);
  localparam int GB    = GRAIN_BITS;

  localparam logic [AW-1:0] COL_STRIDE = AW'(MAX_COLS);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
  localparam logic [GB-1:0] GRAIN_MAX  = '1;

  // Neighbor mask bits
  localparam int NB_UP    = 0;
  localparam int NB_DOWN  = 1;
  localparam int NB_RIGHT = 2;
  localparam int NB_LEFT  = 3;

  // Configuration and budget
  logic [SIZE_CFG_W-1:0] num_rows_r, num_cols_r;
  logic [BUDGET_W-1:0]   budget_r;
  logic [RLW-1:0]        rows_eff;
  logic [CLW-1:0]        cols_eff;

  // Captured item
  logic [CMD_W-1:0]      cmd_r;
  logic [ROW_W-1:0]      row_r;
  logic [COL_W-1:0]      col_r;
  logic [GRAIN_IO_W-1:0] grains_r;

  // Sweep position and toppling state
  logic [RW-1:0]       r_r, r_nxt;
  logic [CW-1:0]       c_r, c_nxt;
  logic [AW-1:0]       cur_r, cur_nxt;
  logic [AW-1:0]       row_base_r, row_base_nxt;
  logic [TOPPLE_W-1:0] topple_r;
  logic [GB-1:0]       share_r;
  logic [3:0]          nb_mask_r;
  logic                row_last, col_last;
  logic                has_up, has_down, has_right, has_left;

  // Clearing pass
  logic [AW-1:0] clr_addr_r;

  // Grain memory
  logic [GB-1:0] grid_mem [DEPTH];
  logic [GB-1:0] rd_data_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [GB-1:0] mem_wdata;

  // Item address and derived values
  logic [AW-1:0]       item_addr, nb_addr;
  logic                cell_in_grid;
  logic [GB-1:0]       load_val;
  logic [GB:0]         nb_sum;
  logic [GB-1:0]       nb_wdata;
  logic                cell_ge4;
  logic [COLOUR_W-1:0] colour;

  // Output register
  logic                  out_valid_r;
  logic [GRAIN_IO_W-1:0] out_grains_r;
  logic [COLOUR_W-1:0]   out_colour_r;
  logic [TOPPLE_W-1:0]   out_topple_r;
  logic                  out_stable_r;
  logic [BUDGET_W-1:0]   out_budget_r;
  logic                  out_free;

  // Grid size in use, clamped to the physical grid
  assign rows_eff = (32'(num_rows_r) > 32'(MAX_ROWS)) ? RLW'(MAX_ROWS) : RLW'(num_rows_r);
  assign cols_eff = (32'(num_cols_r) > 32'(MAX_COLS)) ? CLW'(MAX_COLS) : CLW'(num_cols_r);

  // Load and read target
  assign cell_in_grid = (32'(row_r) < 32'(rows_eff)) && (32'(col_r) < 32'(cols_eff));
  assign item_addr    = AW'(32'(row_r) * MAX_COLS + 32'(col_r));
  assign load_val     = ({32'd0, grains_r} > 64'(GRAIN_MAX)) ? GRAIN_MAX : GB'(grains_r);

  // Position of the sweep cell within the grid in use
  assign row_last  = (RLW'(r_r) == rows_eff - RLW'(1));
  assign col_last  = (CLW'(c_r) == cols_eff - CLW'(1));
  assign has_up    = (r_r != '0);
  assign has_down  = !row_last;
  assign has_right = !col_last;
  assign has_left  = (c_r != '0);

  // Raster step to the next cell
  always_comb begin
    if (col_last) begin
      c_nxt        = '0;
      r_nxt        = r_r + RW'(1);
      row_base_nxt = row_base_r + COL_STRIDE;
      cur_nxt      = row_base_r + COL_STRIDE;
    end else begin
      c_nxt        = c_r + CW'(1);
      r_nxt        = r_r;
      row_base_nxt = row_base_r;
      cur_nxt      = cur_r + AW'(1);
    end
  end

  // Lowest pending neighbor goes first
  always_comb begin
    if (nb_mask_r[NB_UP])        nb_addr = cur_r - COL_STRIDE;
    else if (nb_mask_r[NB_DOWN]) nb_addr = cur_r + COL_STRIDE;
    else if (nb_mask_r[NB_RIGHT]) nb_addr = cur_r + AW'(1);
    else                         nb_addr = cur_r - AW'(1);
  end

  // Saturating neighbor add
  assign nb_sum   = {1'b0, rd_data_r} + {1'b0, share_r};
  assign nb_wdata = nb_sum[GB] ? GRAIN_MAX : nb_sum[GB-1:0];

  // Palette of the read cell
  assign cell_ge4 = |rd_data_r[GB-1:2];
  always_comb begin
    if (cell_ge4) begin
      colour = PAL_MANY;
    end else begin
      case (rd_data_r[1:0])
        2'd0:    colour = PAL_EMPTY;
        2'd1:    colour = PAL_ONE;
        2'd2:    colour = PAL_TWO;
        default: colour = PAL_THREE;
      endcase
    end
  end

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_r;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = cur_r;
    case (op)
      OP_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
      end
      OP_LOAD: begin
        mem_we    = cell_in_grid;
        mem_waddr = item_addr;
        mem_wdata = load_val;
      end
      OP_RD_CELL: begin
        mem_re    = 1'b1;
        mem_raddr = item_addr;
      end
      OP_SW_INIT: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
      end
      OP_SW_STEP_READ: begin
        mem_re    = 1'b1;
        mem_raddr = cur_nxt;
      end
      OP_SW_TOPPLE: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        mem_wdata = GB'(rd_data_r[1:0]);
      end
      OP_NB_RD: begin
        mem_re    = 1'b1;
        mem_raddr = nb_addr;
      end
      OP_NB_WR: begin
        mem_we    = 1'b1;
        mem_waddr = nb_addr;
        mem_wdata = nb_wdata;
      end
      default: ;
    endcase
  end

  // Grain memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= grid_mem[mem_raddr];
  end

  // Configuration, budget, clearing pass and output valid
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r  <= SIZE_RESET;
      num_cols_r  <= SIZE_RESET;
      budget_r    <= BUDGET_RESET;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_ROWS:   num_rows_r <= cfg_data[SIZE_CFG_W-1:0];
          REG_NUM_COLS:   num_cols_r <= cfg_data[SIZE_CFG_W-1:0];
          REG_MAX_SWEEPS: budget_r   <= cfg_data[BUDGET_W-1:0];
          default: ;
        endcase
      end else if (op == OP_SW_END && budget_r != '0) begin
        budget_r <= budget_r - BUDGET_W'(1);
      end
      if (op == OP_CLEAR) clr_addr_r <= clr_addr_r + AW'(1);
      if (op == OP_PUSH)  out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Item capture, sweep bookkeeping and output beat
  always_ff @(posedge clk) begin
    case (op)
      OP_CAPTURE: begin
        cmd_r    <= in_cmd;
        row_r    <= in_row;
        col_r    <= in_col;
        grains_r <= in_grains_in;
      end
      OP_SW_INIT: begin
        r_r        <= '0;
        c_r        <= '0;
        cur_r      <= '0;
        row_base_r <= '0;
        topple_r   <= '0;
      end
      OP_SW_STEP_READ: begin
        r_r        <= r_nxt;
        c_r        <= c_nxt;
        cur_r      <= cur_nxt;
        row_base_r <= row_base_nxt;
      end
      OP_SW_TOPPLE: begin
        share_r   <= rd_data_r >> 2;
        nb_mask_r <= {has_left, has_right, has_down, has_up};
        if (topple_r != '1) topple_r <= topple_r + TOPPLE_W'(1);
      end
      OP_NB_WR: begin
        nb_mask_r <= nb_mask_r & (nb_mask_r - 4'd1);
      end
      OP_PUSH: begin
        out_grains_r <= (cmd_r == CMD_READ && cell_in_grid) ? GRAIN_IO_W'(rd_data_r) : '0;
        out_colour_r <= (cmd_r == CMD_READ && cell_in_grid) ? colour : PAL_EMPTY;
        out_topple_r <= (cmd_r == CMD_SWEEP) ? topple_r : '0;
        out_stable_r <= (cmd_r == CMD_SWEEP) && (topple_r == '0);
        out_budget_r <= budget_r;
      end
      default: ;
    endcase
  end

  // Status to the controller
  assign status.clear_last  = (clr_addr_r == LAST_ADDR);
  assign status.budget_zero = (budget_r == '0);
  assign status.grid_empty  = (rows_eff == '0) || (cols_eff == '0);
  assign status.cell_ge4    = cell_ge4;
  assign status.cell_has_nb = has_up || has_down || has_right || has_left;
  assign status.nb_more     = |(nb_mask_r & (nb_mask_r - 4'd1));
  assign status.sweep_last  = row_last && col_last;
  assign status.out_free    = out_free;

  assign out_valid            = out_valid_r;
  assign out_grains_out       = out_grains_r;
  assign out_colour           = out_colour_r;
  assign out_topple_count     = out_topple_r;
  assign out_stable           = out_stable_r;
  assign out_sweeps_remaining = out_budget_r;

endmodule
`default_nettype wire

// ===== hdl/sandpile_grid_relaxer_unit.sv =====
`default_nettype none
// Channel   Handshake            Payload
// in        in_valid / in_stall  in_cmd, in_row, in_col, in_grains_in
// out       out_valid / out_stall out_grains_out, out_colour, out_topple_count,
//                                out_stable, out_sweeps_remaining
// cfg       cfg_we               cfg_index, cfg_data
//
// A load or a read goes through capture, one memory access and the output beat.
// A sweep visits each cell in use in raster order; a toppling cell also reads
// and writes each in-grid neighbor in turn, since the grain memory has a single
// read and a single write port. After reset a clearing pass writes zero to all
// MAX_ROWS x MAX_COLS cells, one per cycle, with in_stall high; configuration
// writes are taken meanwhile. A stalled output beat holds, and one more item
// is taken and worked on until its own beat waits for the register.
module sandpile_grid_relaxer_unit #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int GRAIN_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sgr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sgr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [sgr_pkg::CMD_W-1:0]        in_cmd,
  input  logic [sgr_pkg::ROW_W-1:0]        in_row,
  input  logic [sgr_pkg::COL_W-1:0]        in_col,
  input  logic [sgr_pkg::GRAIN_IO_W-1:0]   in_grains_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sgr_pkg::GRAIN_IO_W-1:0]   out_grains_out,
  output logic [sgr_pkg::COLOUR_W-1:0]     out_colour,
  output logic [sgr_pkg::TOPPLE_W-1:0]     out_topple_count,
  output logic                             out_stable,
  output logic [sgr_pkg::BUDGET_W-1:0]     out_sweeps_remaining
);
  import sgr_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  // Sequencer
  sgr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .status   (status),
    .op       (op)
  );

  // Grain memory, configuration and output register
  sgr_datapath #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .GRAIN_BITS (GRAIN_BITS)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .op                   (op),
    .status               (status),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_cmd               (in_cmd),
    .in_row               (in_row),
    .in_col               (in_col),
    .in_grains_in         (in_grains_in),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_grains_out       (out_grains_out),
    .out_colour           (out_colour),
    .out_topple_count     (out_topple_count),
    .out_stable           (out_stable),
    .out_sweeps_remaining (out_sweeps_remaining)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
  import sgr_pkg::*;

  localparam int GRID_DIM = 64;
  localparam int TOPPLE_CAP = 8191;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 200000;
  localparam int TAIL_CYCLES = 16;

  // cmd 3 is not a defined command; the block must leave the grid alone
  localparam logic [CMD_W-1:0] CMD_BOGUS = 2'd3;

  typedef struct packed {
    logic [GRAIN_IO_W-1:0] grains;
    logic [COLOUR_W-1:0]   colour;
    logic [TOPPLE_W-1:0]   topples;
    logic                  stable;
    logic [BUDGET_W-1:0]   budget_left;
  } cell_report_t;

  // Grid model plus the queue of reports the block still owes us
  class grid_scoreboard;
    logic [GRAIN_IO_W-1:0] cells [GRID_DIM][GRID_DIM];
    logic [SIZE_CFG_W-1:0] rows_cfg;
    logic [SIZE_CFG_W-1:0] cols_cfg;
    logic [BUDGET_W-1:0]   budget;
    cell_report_t          report_q[$];
    int                    errors;

    function new();
      foreach (cells[r, c]) cells[r][c] = '0;
      rows_cfg = SIZE_RESET;
      cols_cfg = SIZE_RESET;
      budget   = BUDGET_RESET;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_NUM_ROWS:   rows_cfg = data[SIZE_CFG_W-1:0];
        REG_NUM_COLS:   cols_cfg = data[SIZE_CFG_W-1:0];
        REG_MAX_SWEEPS: budget = data;
        default: ;
      endcase
    endfunction

    // sizes above the grid act as the full grid
    function int unsigned rows_used();
      return (rows_cfg > GRID_DIM) ? GRID_DIM : rows_cfg;
    endfunction

    function int unsigned cols_used();
      return (cols_cfg > GRID_DIM) ? GRID_DIM : cols_cfg;
    endfunction

    function int pending();
      return report_q.size();
    endfunction

    static function logic [GRAIN_IO_W-1:0] sat_add(logic [GRAIN_IO_W-1:0] a,
                                                   logic [GRAIN_IO_W-1:0] b);
      logic [GRAIN_IO_W:0] s;
      s = a + b;
      return s[GRAIN_IO_W] ? '1 : s[GRAIN_IO_W-1:0];
    endfunction

    static function logic [COLOUR_W-1:0] palette(logic [GRAIN_IO_W-1:0] g);
      case (g)
        0:       return PAL_EMPTY;
        1:       return PAL_ONE;
        2:       return PAL_TWO;
        3:       return PAL_THREE;
        default: return PAL_MANY;
      endcase
    endfunction

    // One in-place raster pass; cells right and below may gain grains
    // before they are visited
    function int unsigned relax_pass();
      int unsigned nr, nc, toppled;
      logic [GRAIN_IO_W-1:0] g, share;
      nr = rows_used();
      nc = cols_used();
      toppled = 0;
      if (budget == 0) return 0;
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          g = cells[r][c];
          if (g < 4) continue;
          share = g >> 2;
          if (r > 0)      cells[r-1][c] = sat_add(cells[r-1][c], share);
          if (r + 1 < nr) cells[r+1][c] = sat_add(cells[r+1][c], share);
          if (c + 1 < nc) cells[r][c+1] = sat_add(cells[r][c+1], share);
          if (c > 0)      cells[r][c-1] = sat_add(cells[r][c-1], share);
          cells[r][c] = g % 4;
          if (toppled < TOPPLE_CAP) toppled++;
        end
      end
      budget--;
      return toppled;
    endfunction

    // Accepted input beat: update the model and queue the report it owes
    function void note_input(logic [CMD_W-1:0] cmd, logic [ROW_W-1:0] row,
                             logic [COL_W-1:0] col, logic [GRAIN_IO_W-1:0] gin);
      cell_report_t rep;
      bit in_use;
      int unsigned t;
      rep = '0;
      in_use = (row < rows_used()) && (col < cols_used());
      case (cmd)
        CMD_LOAD: if (in_use) cells[row][col] = gin;
        CMD_SWEEP: begin
          t = relax_pass();
          rep.topples = TOPPLE_W'(t);
          rep.stable  = (t == 0);
        end
        CMD_READ: if (in_use) begin
          rep.grains = cells[row][col];
          rep.colour = palette(cells[row][col]);
        end
        default: ;
      endcase
      rep.budget_left = budget;
      report_q.push_back(rep);
    endfunction

    function void flag(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    // Accepted output beat: compare against the oldest report
    function void check_result(cell_report_t got);
      cell_report_t want;
      if (report_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none actual %p",
                 $time, got);
        errors++;
        return;
      end
      want = report_q.pop_front();
      flag("grains_out", want.grains, got.grains);
      flag("colour", want.colour, got.colour);
      flag("topple_count", want.topples, got.topples);
      flag("stable", want.stable, got.stable);
      flag("sweeps_remaining", want.budget_left, got.budget_left);
    endfunction

    function void close_out();
      if (report_q.size() != 0) begin
        $display("%0t: results missing, expected %0d more actual 0", $time,
                 report_q.size());
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_cmd;
  logic [ROW_W-1:0]      in_row;
  logic [COL_W-1:0]      in_col;
  logic [GRAIN_IO_W-1:0] in_grains_in;
  logic                  out_valid;
  logic                  out_stall;
  logic [GRAIN_IO_W-1:0] out_grains_out;
  logic [COLOUR_W-1:0]   out_colour;
  logic [TOPPLE_W-1:0]   out_topple_count;
  logic                  out_stable;
  logic [BUDGET_W-1:0]   out_sweeps_remaining;

  grid_scoreboard sb;
  int send_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_request = 0;

  sandpile_grid_relaxer_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_cmd               (in_cmd),
    .in_row               (in_row),
    .in_col               (in_col),
    .in_grains_in         (in_grains_in),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_grains_out       (out_grains_out),
    .out_colour           (out_colour),
    .out_topple_count     (out_topple_count),
    .out_stable           (out_stable),
    .out_sweeps_remaining (out_sweeps_remaining)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Result side: stall pattern changes at the falling edge
  initial begin : receiver
    int hold_left;
    int hold_seen;
    out_stall = 1'b0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_request != hold_seen) begin
        hold_seen = hold_request;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_grains_out, out_colour, out_topple_count, out_stable,
                       out_sweeps_remaining});
  end

  // Called at a falling edge; returns at the falling edge after the beat
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [ROW_W-1:0] row,
                           logic [COL_W-1:0] col, logic [GRAIN_IO_W-1:0] gin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_row       <= row;
    in_col       <= col;
    in_grains_in <= gin;
    do @(posedge clk); while (in_stall);
    sb.note_input(cmd, row, col, gin);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed report has come back
  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [ROW_W-1:0] pick_coord(int unsigned used);
    if (used > 0 && $urandom_range(99) < 85) return ROW_W'($urandom_range(used - 1));
    return ROW_W'($urandom_range(GRID_DIM - 1));
  endfunction

  // mostly small counts so that sweeps settle; sometimes huge ones
  function automatic logic [GRAIN_IO_W-1:0] pick_grains();
    int p;
    p = $urandom_range(99);
    if (p < 65) return $urandom_range(15);
    if (p < 85) return $urandom_range(255, 16);
    if (p < 95) return $urandom;
    return '1;
  endfunction

  task automatic emit_random();
    int pick;
    logic [CMD_W-1:0]      cmd;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
    logic [GRAIN_IO_W-1:0] gin;
    pick = $urandom_range(99);
    row  = pick_coord(sb.rows_used());
    col  = pick_coord(sb.cols_used());
    gin  = pick_grains();
    if (pick < 42) cmd = CMD_LOAD;
    else if (pick < 72) cmd = CMD_READ;
    else if (pick < 92) cmd = CMD_SWEEP;
    else if (pick < 96) cmd = CMD_BOGUS;
    else begin
      // noise: any command, any fields
      cmd = CMD_W'($urandom_range(3));
      row = ROW_W'($urandom);
      col = COL_W'($urandom);
      gin = $urandom;
    end
    send_item(cmd, row, col, gin);
  endtask

  task automatic run_phase(int items, int sp, int rp, logic [CFG_DATA_W-1:0] rows,
                           logic [CFG_DATA_W-1:0] cols, logic [CFG_DATA_W-1:0] sweeps);
    settle();
    write_reg(REG_NUM_ROWS, rows);
    write_reg(REG_NUM_COLS, cols);
    write_reg(REG_MAX_SWEEPS, sweeps);
    send_idle_pct = sp;
    rcv_stall_pct = rp;
    repeat (items) emit_random();
  endtask

  initial begin
    sb = new();
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_cmd       = '0;
    in_row       = '0;
    in_col       = '0;
    in_grains_in = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset sizes, saturation at the far corner, palette values
    send_item(CMD_READ, 0, 0, 0);
    send_item(CMD_LOAD, 63, 63, '1);
    send_item(CMD_LOAD, 63, 62, '1);
    send_item(CMD_LOAD, 0, 0, 1);
    send_item(CMD_LOAD, 0, 1, 2);
    send_item(CMD_LOAD, 0, 2, 3);
    send_item(CMD_LOAD, 1, 0, 4);
    send_item(CMD_READ, 0, 0, 0);
    send_item(CMD_READ, 0, 1, 0);
    send_item(CMD_READ, 0, 2, 0);
    send_item(CMD_READ, 63, 63, 0);
    send_item(CMD_SWEEP, 0, 0, 0);
    send_item(CMD_READ, 63, 63, 0);
    send_item(CMD_READ, 62, 62, 0);
    send_item(CMD_READ, 1, 1, 0);
    send_item(CMD_BOGUS, 63, 63, '1);
    send_item(CMD_LOAD, 0, 0, 0);
    send_item(CMD_READ, 0, 0, 0);

    // Directed: small grid, junk above the size bits, budget running out
    settle();
    write_reg(REG_NUM_ROWS, 32'd3);
    write_reg(REG_NUM_COLS, 32'hABCD_E002);
    write_reg(REG_MAX_SWEEPS, 32'd2);
    send_item(CMD_LOAD, 5, 0, 9);
    send_item(CMD_READ, 5, 0, 0);
    send_item(CMD_LOAD, 2, 1, 7);
    send_item(CMD_SWEEP, 0, 0, 0);
    send_item(CMD_SWEEP, 0, 0, 0);
    send_item(CMD_SWEEP, 0, 0, 0);

    // Directed: empty grid still spends budget
    settle();
    write_reg(REG_NUM_ROWS, 32'd0);
    write_reg(REG_NUM_COLS, 32'd0);
    write_reg(REG_MAX_SWEEPS, '1);
    send_item(CMD_SWEEP, 0, 0, 0);
    send_item(CMD_READ, 0, 0, 0);

    // Random phases across the idling patterns
    run_phase(20, 0, 0, 6, 6, '1);
    run_phase(17, 84, 0, 8, 5, 10);
    run_phase(17, 0, 84, 1, 64, 5);
    run_phase(17, 13, 13, 64, 1, 3);

    // Receiver holds off while the sender keeps pushing
    settle();
    write_reg(REG_NUM_ROWS, 32'd4);
    write_reg(REG_NUM_COLS, 32'd4);
    write_reg(REG_MAX_SWEEPS, '1);
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_request++;
    repeat (14) emit_random();

    run_phase(17, 13, 13, 127, 127, 32'hFFFF_FFFE);
    run_phase(17, 0, 0, $urandom_range(12, 2), $urandom_range(12, 2), 1);

    settle();
    sb.close_out();
    if (sb.errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
`default_nettype wire
